// ===== sv/rird_pkg.sv =====
// Package for the RTSP interleaved RTP deframer.
// Holds parse phase codes, result and push types, and register indexes.
// No dependencies.
package rird_pkg;

  localparam logic [7:0] DOLLAR_SIGN  = 8'h24;
  localparam int unsigned MASK_WORDS  = 4;
  localparam int unsigned MASK_W      = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = 2;
  localparam int unsigned FIFO_CNT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK_3 = 3'd3;

  typedef enum logic [2:0] {
    PH_SKIP     = 3'd0,
    PH_CHANNEL  = 3'd1,
    PH_LEN_HIGH = 3'd2,
    PH_LEN_LOW  = 3'd3,
    PH_DATA     = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic [7:0] chan;
    logic       last;
  } result_t;

  // Up to two results produced by one item, in order.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== sv/rird_mask.sv =====
// Channel enable mask registers and the per-channel lookup.
// Depends on rird_pkg.
module rird_mask import rird_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MASK_W-1:0]    cfg_data_i,
  input  logic [7:0]           chan_i,
  output logic                 chan_en_o
);

  logic [MASK_WORDS*MASK_W-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CHANNEL_MASK_0: mask_q[0*MASK_W +: MASK_W] <= cfg_data_i;
        CFG_CHANNEL_MASK_1: mask_q[1*MASK_W +: MASK_W] <= cfg_data_i;
        CFG_CHANNEL_MASK_2: mask_q[2*MASK_W +: MASK_W] <= cfg_data_i;
        CFG_CHANNEL_MASK_3: mask_q[3*MASK_W +: MASK_W] <= cfg_data_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  assign chan_en_o = mask_q[chan_i];

endmodule

// ===== sv/rird_parser.sv =====
// Input register and parse state machine: turns each item into 0..2 results.
// Depends on rird_pkg.
module rird_parser import rird_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       room_i,
  output logic [7:0] chan_o,
  input  logic       chan_en_i,
  output push_t      push_o
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        take, fire;

  phase_e      phase_q, phase_d;
  logic [7:0]  held_chan_q, held_chan_d;
  logic [7:0]  len_high_q, len_high_d;
  logic [15:0] remaining_q, remaining_d;

  // The item in the input register moves on only when the queue has room for two.
  assign fire       = in_valid_q & room_i;
  assign in_stall_o = in_valid_q & ~room_i;
  assign take       = in_valid_i & ~in_stall_o;
  assign in_valid_d = take | (in_valid_q & ~room_i);

  assign chan_o = in_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PH_SKIP;
      held_chan_q <= '0;
      len_high_q  <= '0;
      remaining_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      phase_q     <= phase_d;
      held_chan_q <= held_chan_d;
      len_high_q  <= len_high_d;
      remaining_q <= remaining_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= data_byte_i;
    end
  end

  function automatic result_t mk_res(logic [7:0] d, logic k, logic [7:0] c, logic l);
    result_t r;
    r.data = d;
    r.kind = k;
    r.chan = c;
    r.last = l;
    return r;
  endfunction

  always_comb begin
    logic [15:0] len_full;
    logic [15:0] rem_dec;
    len_full    = {len_high_q, in_byte_q};
    rem_dec     = remaining_q - 16'd1;
    phase_d     = phase_q;
    held_chan_d = held_chan_q;
    len_high_d  = len_high_q;
    remaining_d = remaining_q;
    push_o      = '0;
    if (fire) begin
      unique case (phase_q)
        PH_CHANNEL: begin
          if (chan_en_i) begin
            held_chan_d  = in_byte_q;
            phase_d      = PH_LEN_HIGH;
            push_o.num   = 2'd2;
            push_o.first = mk_res(DOLLAR_SIGN, 1'b1, in_byte_q, 1'b0);
            push_o.second = mk_res(in_byte_q, 1'b1, in_byte_q, 1'b0);
          end else begin
            // Held '$' goes out as body; the new byte is handled as in skip phase.
            push_o.first = mk_res(DOLLAR_SIGN, 1'b0, 8'd0, 1'b0);
            if (in_byte_q == DOLLAR_SIGN) begin
              phase_d    = PH_CHANNEL;
              push_o.num = 2'd1;
            end else begin
              phase_d       = PH_SKIP;
              push_o.num    = 2'd2;
              push_o.second = mk_res(in_byte_q, 1'b0, 8'd0, 1'b0);
            end
          end
        end
        PH_LEN_HIGH: begin
          len_high_d   = in_byte_q;
          phase_d      = PH_LEN_LOW;
          push_o.num   = 2'd1;
          push_o.first = mk_res(in_byte_q, 1'b1, held_chan_q, 1'b0);
        end
        PH_LEN_LOW: begin
          remaining_d  = len_full;
          phase_d      = (len_full == 16'd0) ? PH_SKIP : PH_DATA;
          push_o.num   = 2'd1;
          push_o.first = mk_res(in_byte_q, 1'b1, held_chan_q, len_full == 16'd0);
        end
        PH_DATA: begin
          remaining_d  = rem_dec;
          phase_d      = (rem_dec == 16'd0) ? PH_SKIP : PH_DATA;
          push_o.num   = 2'd1;
          push_o.first = mk_res(in_byte_q, 1'b1, held_chan_q, rem_dec == 16'd0);
        end
        default: begin
          if (in_byte_q == DOLLAR_SIGN) begin
            phase_d = PH_CHANNEL;
          end else begin
            phase_d      = PH_SKIP;
            push_o.num   = 2'd1;
            push_o.first = mk_res(in_byte_q, 1'b0, 8'd0, 1'b0);
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/rird_out_fifo.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on rird_pkg.
module rird_out_fifo import rird_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_res_o
);

  result_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]  count_q, count_d;
  logic                   pop;

  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & ~out_stall_i;
  // Room for a two-result item regardless of this cycle's pop.
  assign room_o      = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  assign count_d = count_q + FIFO_CNT_W'(push_i.num) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.num;
      rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push_i.second;
    end
  end

endmodule

// ===== sv/rtsp_interleaved_rtp_deframer.sv =====
// RTSP interleaved deframer: splits a byte stream into body bytes and
// channel-tagged interleaved packet bytes.
//
// Input channel: in_valid_i / in_stall_o with one stream byte per item.
// Output channel: out_valid_o / out_stall_i, one byte per item with its kind,
// packet channel and last-byte mark.
// Configuration: cfg_we_i writes cfg_data_i to channel mask word cfg_index_i
// (0..3, channels 64*i .. 64*i+63); other indexes are ignored. Write only
// while idle.
// Path: an accepted item is held in the input register, then its results are written to the result queue.
// Throughput: one item per cycle. A '$' followed by a channel byte yields two
// results from one item; these drain through a four-entry result queue,
// and input stalls when fewer than two queue slots are free.
// Reset: clears the masks (all channels disabled), the parse state and the
// result queue.
// Output stall: results wait in the queue with the head held steady; once
// more than two results are queued the input register holds its item and
// in_stall_o rises in the same cycle.
module rtsp_interleaved_rtp_deframer import rird_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_kind_o,
  output logic [7:0]           packet_channel_o,
  output logic                 packet_last_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MASK_W-1:0]    cfg_data_i
);

  logic       room;
  logic [7:0] chan;
  logic       chan_en;
  push_t      push;
  result_t    res;

  rird_mask u_mask (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .chan_i      (chan),
    .chan_en_o   (chan_en)
  );

  rird_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .room_i      (room),
    .chan_o      (chan),
    .chan_en_i   (chan_en),
    .push_o      (push)
  );

  rird_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  assign out_byte_o       = res.data;
  assign out_kind_o       = res.kind;
  assign packet_channel_o = res.chan;
  assign packet_last_o    = res.last;

endmodule

// ===== sv/rird_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
// Depends only on the top level's handshake and result ports.
module rird_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic [7:0]           out_byte_o,
  input  logic                 out_kind_o,
  input  logic [7:0]           packet_channel_o,
  input  logic                 packet_last_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_kind_o) && $stable(packet_channel_o) && $stable(packet_last_o))
    else $error("stalled output item changed");

  // A stalled input item stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(data_byte_i))
    else $error("stalled input item changed");

  // Only a packet byte can close a packet.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_last_o |-> out_kind_o)
    else $error("last mark on a body byte");

  // Body bytes carry no channel.
  a_body_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_kind_o |-> packet_channel_o == 8'd0)
    else $error("body byte with channel set");

  // Nothing is offered while reset is held.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind rtsp_interleaved_rtp_deframer rird_checker u_rird_checker (.*);
